>>> rtl/core/cmad_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmad_pkg - shared types and constants for the calendar minute core
// Stream widths, pipeline depth, calendar constants and the month table for
// a fixed 365-day year with no leap day.
// ----------------------------------------------------------------------------
package cmad_pkg;

	// Stream payload widths, padded to whole bytes
	localparam int IN_TDATA_W  = 64;
	localparam int OUT_TDATA_W = 48;

	// Pipeline depth, input register through result register
	localparam int NUM_STAGES = 8;
	localparam int CNT_W      = $clog2(NUM_STAGES + 1);

	// Calendar constants
	localparam int NUM_MONTHS     = 12;
	localparam int MIN_PER_HOUR   = 60;
	localparam int MIN_PER_DAY    = 24 * MIN_PER_HOUR;
	localparam int MIN_PER_YEAR   = 365 * MIN_PER_DAY;

	// Reciprocal constants for division by 45 (after >>5, i.e. by 1440)
	// and by 15 (after >>2, i.e. by 60)
	localparam int DAY_RCP       = 23302;
	localparam int DAY_RCP_SHIFT = 20;
	localparam int HR_RCP        = 1093;
	localparam int HR_RCP_SHIFT  = 14;

	// Result of the compare path carried down the pipe
	typedef struct packed {
		logic [20:0] diff;
		logic        lt;
	} cmp_t;

	// Days in the year before the first day of the given month (1..12)
	function automatic logic [8:0] cum_days(input logic [3:0] month);
		logic [8:0] days;
		unique case (month)
			4'd1:    days = 9'd0;
			4'd2:    days = 9'd31;
			4'd3:    days = 9'd59;
			4'd4:    days = 9'd90;
			4'd5:    days = 9'd120;
			4'd6:    days = 9'd151;
			4'd7:    days = 9'd181;
			4'd8:    days = 9'd212;
			4'd9:    days = 9'd243;
			4'd10:   days = 9'd273;
			4'd11:   days = 9'd304;
			4'd12:   days = 9'd334;
			default: days = 9'd0;
		endcase
		return days;
	endfunction

	// Force a month code into 1..12
	function automatic logic [3:0] clamp_month(input logic [3:0] month);
		logic [3:0] m;
		if (month == 4'd0) begin
			m = 4'd1;
		end else if (month > 4'(NUM_MONTHS)) begin
			m = 4'(NUM_MONTHS);
		end else begin
			m = month;
		end
		return m;
	endfunction

endpackage

>>> rtl/core/calendar_minute_add_diff_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calendar_minute_add_diff_core - minute arithmetic over a 365-day year
// Adds a signed minute offset to date-time A with wrap over the year, and
// returns A minus B in minutes and whether A is strictly before B.
//
//  Channel   Dir  Handshake                    Payload
//  s_axis    in   s_axis_tvalid/s_axis_tready  A, B, offset (64-bit tdata)
//  m_axis    out  m_axis_tvalid/m_axis_tready  sum date-time, diff, flag
//
// One request per clock cycle sustained while m_axis_tready is high; every request
// passes through an eight-stage pipeline (input register to result register).
// Each stage has its own valid bit and fills while a later stage is stalled,
// so the core keeps taking requests until all eight stages hold one.
// Reset clears only the stage valid bits; the payload registers are free.
// ----------------------------------------------------------------------------
module calendar_minute_add_diff_core (
	input  logic                             clk,
	input  logic                             arst_n,
	// first_month, first_day, first_hour, first_minute, second_month,
	// second_day, second_hour, second_minute, offset_minutes, zero pad
	input  logic [cmad_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// sum_month, sum_day, sum_hour, sum_minute, diff_minutes,
	// first_is_earlier, zero pad
	output logic [cmad_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready
);
	import cmad_pkg::*;

	// Stage control
	logic [NUM_STAGES:1]   vld_q;
	logic [NUM_STAGES+1:1] rdy;
	logic [NUM_STAGES:1]   load;

	// Stage 1: raw fields
	logic [3:0]         a_mon_s1, b_mon_s1;
	logic [4:0]         a_day_s1, b_day_s1;
	logic [4:0]         a_hr_s1, b_hr_s1;
	logic [5:0]         a_min_s1, b_min_s1;
	logic signed [20:0] off_s1;

	// Stage 2: minute of year
	logic signed [9:0]  a_doy, b_doy;
	logic signed [20:0] pa, pb;
	logic signed [20:0] pa_s2, pb_s2, off_s2;

	// Stage 3: raw sum and compare
	logic signed [21:0] sum_s3;
	cmp_t               cmp_s3;

	// Stage 4: sum wrapped into the year
	logic signed [21:0] wrap_full;
	logic [19:0]        tmod_s4;
	cmp_t               cmp_s4;

	// Stage 5: day of year
	logic [29:0]        doy_prod;
	logic [8:0]         doy_s5;
	logic [19:0]        tmod_s5;
	cmp_t               cmp_s5;

	// Stage 6: minute of day, month and day of month
	logic [19:0]        rem_full;
	logic [3:0]         mon_sel;
	logic [8:0]         mon_base;
	logic [8:0]         day_full;
	logic [10:0]        rem_s6;
	logic [3:0]         mon_s6;
	logic [4:0]         day_s6;
	cmp_t               cmp_s6;

	// Stage 7: hour
	logic [19:0]        hr_prod;
	logic [4:0]         hr_s7;
	logic [10:0]        rem_s7;
	logic [3:0]         mon_s7;
	logic [4:0]         day_s7;
	cmp_t               cmp_s7;

	// Stage 8: result register
	logic [10:0]        min_full;
	logic [3:0]         mon_s8;
	logic [4:0]         day_s8;
	logic [4:0]         hr_s8;
	logic [5:0]         min_s8;
	cmp_t               cmp_s8;

	// Ready ripples back: a stage takes a new request when empty or draining
	always_comb begin
		rdy[NUM_STAGES+1] = m_axis_tready;
		for (int k = NUM_STAGES; k >= 1; k--) begin
			rdy[k] = !vld_q[k] || rdy[k+1];
		end
		load[1] = rdy[1] && s_axis_tvalid;
		for (int k = 2; k <= NUM_STAGES; k++) begin
			load[k] = rdy[k] && vld_q[k-1];
		end
	end

	// Advance the valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (rdy[1]) begin
				vld_q[1] <= s_axis_tvalid;
			end
			for (int k = 2; k <= NUM_STAGES; k++) begin
				if (rdy[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign s_axis_tready = rdy[1];
	assign m_axis_tvalid = vld_q[NUM_STAGES];

	// Stage 1: capture the request
	always_ff @(posedge clk) begin
		if (load[1]) begin
			a_mon_s1 <= s_axis_tdata[3:0];
			a_day_s1 <= s_axis_tdata[8:4];
			a_hr_s1  <= s_axis_tdata[13:9];
			a_min_s1 <= s_axis_tdata[19:14];
			b_mon_s1 <= s_axis_tdata[23:20];
			b_day_s1 <= s_axis_tdata[28:24];
			b_hr_s1  <= s_axis_tdata[33:29];
			b_min_s1 <= s_axis_tdata[39:34];
			off_s1   <= $signed(s_axis_tdata[60:40]);
		end
	end

	// Stage 2: map each date-time to its minute of the year
	always_comb begin
		a_doy = $signed({1'b0, cum_days(clamp_month(a_mon_s1))})
			+ $signed({5'b0, a_day_s1}) - 10'sd1;
		b_doy = $signed({1'b0, cum_days(clamp_month(b_mon_s1))})
			+ $signed({5'b0, b_day_s1}) - 10'sd1;
		pa = $signed({{11{a_doy[9]}}, a_doy}) * 21'(MIN_PER_DAY)
			+ $signed({16'b0, a_hr_s1}) * 21'(MIN_PER_HOUR)
			+ $signed({15'b0, a_min_s1});
		pb = $signed({{11{b_doy[9]}}, b_doy}) * 21'(MIN_PER_DAY)
			+ $signed({16'b0, b_hr_s1}) * 21'(MIN_PER_HOUR)
			+ $signed({15'b0, b_min_s1});
	end

	always_ff @(posedge clk) begin
		if (load[2]) begin
			pa_s2  <= pa;
			pb_s2  <= pb;
			off_s2 <= off_s1;
		end
	end

	// Stage 3: add the offset, subtract B, compare
	always_ff @(posedge clk) begin
		if (load[3]) begin
			sum_s3      <= $signed({pa_s2[20], pa_s2}) + $signed({off_s2[20], off_s2});
			cmp_s3.diff <= pa_s2 - pb_s2;
			cmp_s3.lt   <= pa_s2 < pb_s2;
		end
	end

	// Stage 4: floor modulo by the year length
	always_comb begin
		if (sum_s3 >= 22'sd3 * 22'(MIN_PER_YEAR)) begin
			wrap_full = sum_s3 - 22'sd3 * 22'(MIN_PER_YEAR);
		end else if (sum_s3 >= 22'sd2 * 22'(MIN_PER_YEAR)) begin
			wrap_full = sum_s3 - 22'sd2 * 22'(MIN_PER_YEAR);
		end else if (sum_s3 >= 22'(MIN_PER_YEAR)) begin
			wrap_full = sum_s3 - 22'(MIN_PER_YEAR);
		end else if (sum_s3 >= 22'sd0) begin
			wrap_full = sum_s3;
		end else if (sum_s3 >= -22'(MIN_PER_YEAR)) begin
			wrap_full = sum_s3 + 22'(MIN_PER_YEAR);
		end else begin
			wrap_full = sum_s3 + 22'sd2 * 22'(MIN_PER_YEAR);
		end
	end

	always_ff @(posedge clk) begin
		if (load[4]) begin
			tmod_s4 <= wrap_full[19:0];
			cmp_s4  <= cmp_s3;
		end
	end

	// Stage 5: day of year, t / 1440 as (t >> 5) / 45 by reciprocal
	assign doy_prod = 30'(tmod_s4[19:5]) * 30'(DAY_RCP);

	always_ff @(posedge clk) begin
		if (load[5]) begin
			doy_s5  <= doy_prod[DAY_RCP_SHIFT+8:DAY_RCP_SHIFT];
			tmod_s5 <= tmod_s4;
			cmp_s5  <= cmp_s4;
		end
	end

	// Stage 6: minute of day, and month by search of the month table
	always_comb begin
		rem_full = tmod_s5 - 20'(doy_s5) * 20'(MIN_PER_DAY);
		mon_sel  = 4'd1;
		mon_base = 9'd0;
		for (int m = 2; m <= NUM_MONTHS; m++) begin
			if (doy_s5 >= cum_days(4'(m))) begin
				mon_sel  = 4'(m);
				mon_base = cum_days(4'(m));
			end
		end
		day_full = doy_s5 - mon_base + 9'd1;
	end

	always_ff @(posedge clk) begin
		if (load[6]) begin
			rem_s6 <= rem_full[10:0];
			mon_s6 <= mon_sel;
			day_s6 <= day_full[4:0];
			cmp_s6 <= cmp_s5;
		end
	end

	// Stage 7: hour, rem / 60 as (rem >> 2) / 15 by reciprocal
	assign hr_prod = 20'(rem_s6[10:2]) * 20'(HR_RCP);

	always_ff @(posedge clk) begin
		if (load[7]) begin
			hr_s7  <= hr_prod[HR_RCP_SHIFT+4:HR_RCP_SHIFT];
			rem_s7 <= rem_s6;
			mon_s7 <= mon_s6;
			day_s7 <= day_s6;
			cmp_s7 <= cmp_s6;
		end
	end

	// Stage 8: minute and result register
	assign min_full = rem_s7 - 11'(hr_s7) * 11'(MIN_PER_HOUR);

	always_ff @(posedge clk) begin
		if (load[8]) begin
			mon_s8 <= mon_s7;
			day_s8 <= day_s7;
			hr_s8  <= hr_s7;
			min_s8 <= min_full[5:0];
			cmp_s8 <= cmp_s7;
		end
	end

	assign m_axis_tdata = {6'b0, cmp_s8.lt, cmp_s8.diff, min_s8, hr_s8, day_s8, mon_s8};

endmodule

>>> rtl/core/cmad_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmad_checker - port-level checks for the calendar minute core
// Tracks requests in flight from the two handshakes and checks output
// hold, occupancy and back-pressure behavior.
// ----------------------------------------------------------------------------
module cmad_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	input  logic                             s_axis_tready,
	input  logic [cmad_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	input  logic                             m_axis_tvalid,
	input  logic                             m_axis_tready
);
	import cmad_pkg::*;

	logic             in_acc;
	logic             out_acc;
	logic [CNT_W-1:0] inflight_q;

	assign in_acc  = s_axis_tvalid && s_axis_tready;
	assign out_acc = m_axis_tvalid && m_axis_tready;

	// Count requests taken but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			inflight_q <= inflight_q + CNT_W'(in_acc) - CNT_W'(out_acc);
		end
	end

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed or dropped while stalled");

	// No result without a request in flight
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> inflight_q != '0)
		else $error("result shown with no request in flight");

	// Never more requests in flight than pipeline stages
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= CNT_W'(NUM_STAGES))
		else $error("more requests in flight than stages");

	// Refuse requests only when the output is backed up
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("input stalled while output is free");

endmodule

bind calendar_minute_add_diff_core cmad_checker u_cmad_checker (.*);
